[rtl/indexed_min_heap_update_key_macros.svh]
// ----------------------------------------------------------------------------
// indexed min-heap assertion macros
// assertion forms used by the heap datapath
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_UPDATE_KEY_MACROS_SVH
`define INDEXED_MIN_HEAP_UPDATE_KEY_MACROS_SVH

// same-cycle implication
`define IMH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/imhuk_pkg.sv]
// ----------------------------------------------------------------------------
// imhuk_pkg
// types and constants for the indexed min-heap
// ----------------------------------------------------------------------------
`default_nettype none

package imhuk_pkg;

  localparam int CAPACITY   = 1024;
  localparam int KEY_BITS   = 32;
  localparam int ITEM_BITS  = 10;
  localparam int ITEM_SPACE = 1 << ITEM_BITS;
  localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int PTR_W      = CNT_W + 1;

  localparam logic CMD_PUT    = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PUT_REJ = 2'd1;
  localparam logic [1:0] ST_UPD_REJ = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  item;
    logic [31:0] key;
  } in_t;

  typedef struct packed {
    logic [9:0]       top_item;
    logic [31:0]      top_key;
    logic [CNT_W-1:0] count;
    logic [1:0]       status;
  } out_t;

  typedef struct packed {
    logic [ITEM_BITS-1:0] id;
    logic [KEY_BITS-1:0]  key;
  } heap_ent_t;

  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } itm_ent_t;

  typedef struct packed {
    logic       clr_step;
    logic       load_in;
    logic       start_put;
    logic       start_upd;
    logic       status_we;
    logic [1:0] status_val;
    logic       up_rd;
    logic       up_move;
    logic       dn_rd_l;
    logic       dn_lat_l;
    logic       dn_rd_r;
    logic       dn_sel_r;
    logic       dn_move;
    logic       place;
    logic       top_rd;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_put;
    logic full;
    logic present;
    logic i_zero;
    logic up_gt;
    logic has_l;
    logic has_r;
    logic dn_gt;
    logic out_blocked;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/imhuk_ram.sv]
// ----------------------------------------------------------------------------
// imhuk_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module imhuk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/imhuk_dp.sv]
// ----------------------------------------------------------------------------
// imhuk_dp
// heap datapath: slot and item memories, sift registers, result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_min_heap_update_key_macros.svh"

module imhuk_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire imhuk_pkg::dp_cmd_t cmd,
  output imhuk_pkg::dp_sts_t     sts,
  input  wire imhuk_pkg::in_t    in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output imhuk_pkg::out_t        out_data
);

  import imhuk_pkg::*;

  logic                 cmd_r;
  logic [ITEM_BITS-1:0] id_r;
  logic [KEY_BITS-1:0]  k_r;
  logic [SLOT_W-1:0]    i_r, i_nxt;
  logic [SLOT_W-1:0]    j_r;
  heap_ent_t            c_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [1:0]           status_r;
  logic [ITEM_BITS-1:0] clr_r;
  logic                 out_valid_r;
  out_t                 out_r;

  heap_ent_t            heap_rd, heap_wd;
  logic                 heap_we, heap_re;
  logic [SLOT_W-1:0]    heap_wa, heap_ra;
  itm_ent_t             itm_rd, itm_wd;
  logic                 itm_we;
  logic [ITEM_BITS-1:0] itm_wa;

  logic [PTR_W-1:0]     l_w, r_w;
  logic [SLOT_W-1:0]    p_w;

  assign l_w = PTR_W'({i_r, 1'b1});
  assign r_w = l_w + PTR_W'(1);
  assign p_w = SLOT_W'((i_r - SLOT_W'(1)) >> 1);

  imhuk_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_wa),
    .wdata (heap_wd),
    .re    (heap_re),
    .raddr (heap_ra),
    .rdata (heap_rd)
  );

  imhuk_ram #(.WIDTH($bits(itm_ent_t)), .DEPTH(ITEM_SPACE)) u_itm (
    .clk   (clk),
    .we    (itm_we),
    .waddr (itm_wa),
    .wdata (itm_wd),
    .re    (cmd.load_in),
    .raddr (in_data.item),
    .rdata (itm_rd)
  );

  always_comb begin
    heap_re = cmd.up_rd | cmd.dn_rd_l | cmd.dn_rd_r | cmd.top_rd;
    heap_ra = '0;
    if (cmd.up_rd) begin
      heap_ra = p_w;
    end else if (cmd.dn_rd_l) begin
      heap_ra = SLOT_W'(l_w);
    end else if (cmd.dn_rd_r) begin
      heap_ra = SLOT_W'(r_w);
    end
    heap_we = cmd.up_move | cmd.dn_move | cmd.place;
    heap_wa = i_r;
    heap_wd = '{id: id_r, key: k_r};
    if (cmd.up_move) begin
      heap_wd = heap_rd;
    end else if (cmd.dn_move) begin
      heap_wd = c_r;
    end
    itm_we = cmd.clr_step | heap_we;
    itm_wa = id_r;
    itm_wd = '{present: 1'b1, slot: i_r};
    if (cmd.clr_step) begin
      itm_wa = clr_r;
      itm_wd = '0;
    end else if (cmd.up_move) begin
      itm_wa = heap_rd.id;
    end else if (cmd.dn_move) begin
      itm_wa = c_r.id;
    end
  end

  always_comb begin
    i_nxt = i_r;
    if (cmd.start_put) begin
      i_nxt = SLOT_W'(count_r);
    end else if (cmd.start_upd) begin
      i_nxt = itm_rd.slot;
    end else if (cmd.up_move) begin
      i_nxt = p_w;
    end else if (cmd.dn_move) begin
      i_nxt = j_r;
    end
    count_nxt = count_r + CNT_W'(cmd.start_put);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.clr_step) begin
        clr_r <= clr_r + ITEM_BITS'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    if (cmd.load_in) begin
      cmd_r    <= in_data.cmd;
      id_r     <= in_data.item;
      k_r      <= KEY_BITS'(in_data.key);
      status_r <= ST_OK;
    end
    if (cmd.status_we) begin
      status_r <= cmd.status_val;
    end
    if (cmd.dn_lat_l) begin
      c_r <= heap_rd;
      j_r <= SLOT_W'(l_w);
    end
    if (cmd.dn_sel_r && !(c_r.key < heap_rd.key)) begin
      c_r <= heap_rd;
      j_r <= SLOT_W'(r_w);
    end
    if (cmd.out_load) begin
      out_r.count  <= count_r;
      out_r.status <= status_r;
      if (count_r == '0) begin
        out_r.top_item <= '0;
        out_r.top_key  <= '0;
      end else begin
        out_r.top_item <= heap_rd.id;
        out_r.top_key  <= 32'(heap_rd.key);
      end
    end
  end

  always_comb begin
    sts.clr_done    = (clr_r == '1);
    sts.is_put      = (cmd_r == CMD_PUT);
    sts.full        = (count_r == CNT_W'(CAPACITY));
    sts.present     = itm_rd.present;
    sts.i_zero      = (i_r == '0);
    sts.up_gt       = (heap_rd.key > k_r);
    sts.has_l       = (l_w < PTR_W'(count_r));
    sts.has_r       = (r_w < PTR_W'(count_r));
    sts.dn_gt       = (k_r > c_r.key);
    sts.out_blocked = out_valid_r & out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `IMH_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY), "count over capacity")
  `IMH_ASSERT_NXT(a_count_inc, clk, rst_n, cmd.start_put, count_r == $past(count_r) + CNT_W'(1), "count step")
  `IMH_ASSERT_IMP(a_place_slot, clk, rst_n, cmd.place, PTR_W'(i_r) < PTR_W'(count_r), "slot past end")

endmodule

`default_nettype wire

[rtl/imhuk_ctrl.sv]
// ----------------------------------------------------------------------------
// imhuk_ctrl
// sequencer for clear pass, command check, sift up, sift down and result output
// ----------------------------------------------------------------------------
`default_nettype none

module imhuk_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire imhuk_pkg::dp_sts_t sts,
  output imhuk_pkg::dp_cmd_t      cmd
);

  import imhuk_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_UP    = 4'd3;
  localparam logic [3:0] S_UPW   = 4'd4;
  localparam logic [3:0] S_DN    = 4'd5;
  localparam logic [3:0] S_DNL   = 4'd6;
  localparam logic [3:0] S_DNR   = 4'd7;
  localparam logic [3:0] S_DNC   = 4'd8;
  localparam logic [3:0] S_PLACE = 4'd9;
  localparam logic [3:0] S_TOP   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.is_put) begin
          if (sts.full || sts.present) begin
            cmd.status_we  = 1'b1;
            cmd.status_val = ST_PUT_REJ;
            state_nxt      = S_TOP;
          end else begin
            cmd.start_put = 1'b1;
            state_nxt     = S_UP;
          end
        end else begin
          if (!sts.present) begin
            cmd.status_we  = 1'b1;
            cmd.status_val = ST_UPD_REJ;
            state_nxt      = S_TOP;
          end else begin
            cmd.start_upd = 1'b1;
            state_nxt     = S_UP;
          end
        end
      end
      S_UP: begin
        if (sts.i_zero) begin
          state_nxt = sts.is_put ? S_PLACE : S_DN;
        end else begin
          cmd.up_rd = 1'b1;
          state_nxt = S_UPW;
        end
      end
      S_UPW: begin
        if (sts.up_gt) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP;
        end else begin
          state_nxt = sts.is_put ? S_PLACE : S_DN;
        end
      end
      S_DN: begin
        if (sts.has_l) begin
          cmd.dn_rd_l = 1'b1;
          state_nxt   = S_DNL;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DNL: begin
        cmd.dn_lat_l = 1'b1;
        if (sts.has_r) begin
          cmd.dn_rd_r = 1'b1;
          state_nxt   = S_DNR;
        end else begin
          state_nxt = S_DNC;
        end
      end
      S_DNR: begin
        cmd.dn_sel_r = 1'b1;
        state_nxt    = S_DNC;
      end
      S_DNC: begin
        if (sts.dn_gt) begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        cmd.top_rd = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_blocked) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/indexed_min_heap_update_key.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap_update_key
// indexed binary min-heap event queue with put and key update
//
//   channel  dir  handshake            item
//   in       in   in_valid/in_stall    cmd, item, key
//   out      out  out_valid/out_stall  top_item, top_key, count, status
//
// after reset the item map is cleared one entry a cycle, in_stall high
// a put is checked, climbs a level per parent read and compare, is placed, then the top is read
// an update climbs like a put, then descends, reading the left and any right child per level
// each heap level costs a read and a compare on the single read port of the slot ram
// a refused item skips the sift and goes straight to the top read and the result load
// out_stall holds the result register; the next item is taken while it waits
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_update_key (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire imhuk_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output imhuk_pkg::out_t      out_data
);

  import imhuk_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  imhuk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  imhuk_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the indexed min-heap event queue: random put and
// update items with random gaps and receiver stalls, results checked against
// a heap model kept inside the scoreboard
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import imhuk_pkg::*;

  class heap_scoreboard;
    logic [9:0]  slots [1024];
    logic [31:0] keys [1024];
    int unsigned where [1024];
    bit          held [1024];
    int unsigned n;
    out_t        pending [$];
    int          errors;

    function new();
      n = 0;
      errors = 0;
      foreach (held[i]) held[i] = 0;
    endfunction

    function void put_at(int unsigned s, logic [9:0] id);
      slots[s] = id;
      where[id] = s;
    endfunction

    function void climb(logic [9:0] id);
      int unsigned i;
      int unsigned p;
      i = where[id];
      while (i > 0) begin
        p = (i - 1) / 2;
        if (keys[slots[p]] > keys[id]) begin
          put_at(i, slots[p]);
          i = p;
        end else break;
      end
      put_at(i, id);
    endfunction

    function void descend(logic [9:0] id);
      int unsigned i;
      int unsigned l;
      int unsigned j;
      i = where[id];
      while (2 * i + 1 < n) begin
        l = 2 * i + 1;
        j = l;
        if (l + 1 < n && !(keys[slots[l]] < keys[slots[l + 1]])) j = l + 1;
        if (keys[id] > keys[slots[j]]) begin
          put_at(i, slots[j]);
          i = j;
        end else break;
      end
      put_at(i, id);
    endfunction

    function void note_item(in_t x);
      out_t r;
      r.status = ST_OK;
      if (x.cmd == CMD_PUT) begin
        if (n >= CAPACITY || held[x.item]) r.status = ST_PUT_REJ;
        else begin
          held[x.item] = 1;
          keys[x.item] = x.key;
          put_at(n, x.item);
          n++;
          climb(x.item);
        end
      end else begin
        if (!held[x.item]) r.status = ST_UPD_REJ;
        else begin
          keys[x.item] = x.key;
          climb(x.item);
          descend(x.item);
        end
      end
      r.top_item = (n > 0) ? slots[0] : '0;
      r.top_key  = (n > 0) ? keys[slots[0]] : '0;
      r.count    = CNT_W'(n);
      pending.push_back(r);
    endfunction

    function void check_result(out_t y);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item %p", y);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (y.top_item !== e.top_item) begin
        $error("top_item exp %0d got %0d", e.top_item, y.top_item); errors++;
      end
      if (y.top_key !== e.top_key) begin
        $error("top_key exp %0h got %0h", e.top_key, y.top_key); errors++;
      end
      if (y.count !== e.count) begin
        $error("count exp %0d got %0d", e.count, y.count); errors++;
      end
      if (y.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, y.status); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;

  heap_scoreboard sb = new();
  int   quiet = 0;
  bit   hold_long = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  indexed_min_heap_update_key u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_item(in_data);
      quiet <= 0;
    end else if (rst_n && out_valid && !out_stall) quiet <= 0;
    else quiet <= quiet + 1;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (quiet > 5000) begin
      $display("indexed_min_heap_update_key regression: fail");
      $finish;
    end
  end

  // receiver stall process
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_long = 0;
      end
      g = gap_len();
      if (g == 0 || $urandom_range(0, 3) == 0) begin
        out_stall <= 0;
        @(posedge clk);
      end else begin
        out_stall <= 1;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic send(logic c, logic [9:0] id, logic [31:0] k, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= '{cmd: c, item: id, key: k};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  logic [9:0] live [$];

  task automatic rand_item(int phase);
    int r;
    logic [9:0] id;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: k = $urandom_range(0, 15);
      1: k = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: k = $urandom();
    endcase
    if (r < 50 && phase == 0 || r < 10) begin
      id = 10'($urandom_range(0, 1023));
      send(CMD_PUT, id, k, 1);
    end else if (r < 90 && live.size() > 0) begin
      id = live[$urandom_range(0, live.size() - 1)];
      send(CMD_UPDATE, id, k, 1);
    end else begin
      id = 10'($urandom_range(0, 1023));
      send(1'($urandom_range(0, 1)), id, k, 1);
    end
  endtask

  initial begin
    int i;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: empty update, extremes, equal keys, lone left child, duplicate put
    send(CMD_UPDATE, 10'd5, 32'd7, 0);
    send(CMD_PUT, 10'd0, 32'hFFFF_FFFF, 0);
    send(CMD_PUT, 10'd1023, 32'd0, 0);
    send(CMD_PUT, 10'd1023, 32'd3, 0);
    send(CMD_PUT, 10'd512, 32'd100, 0);
    send(CMD_PUT, 10'd511, 32'd100, 0);
    send(CMD_PUT, 10'd341, 32'd100, 0);
    send(CMD_PUT, 10'd682, 32'd100, 0);
    send(CMD_UPDATE, 10'd1023, 32'hFFFF_FFFF, 0);
    send(CMD_UPDATE, 10'd0, 32'd0, 0);
    send(CMD_UPDATE, 10'd0, 32'd200, 0);
    send(CMD_UPDATE, 10'd341, 32'd50, 0);
    send(CMD_UPDATE, 10'd341, 32'd50, 0);
    send(CMD_UPDATE, 10'd7, 32'd1, 0);
    send(CMD_PUT, 10'd0, 32'd1, 0);
    foreach (sb.held[j]) if (sb.held[j]) live.push_back(10'(j));
    // mostly puts first, pressure stretch in the middle
    for (i = 0; i < 500; i++) begin
      if (i == 150) hold_long = 1;
      rand_item(i < 250 ? 0 : 1);
      if (in_data.cmd == CMD_PUT && !(in_data.item inside {live})) begin
        live.push_back(in_data.item);
      end
    end
    send(CMD_PUT, 10'd3, 32'd9, 0);
    send(CMD_UPDATE, 10'd3, 32'd0, 1);
    send(CMD_UPDATE, 10'd900, 32'hFFFF_FFFF, 1);
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("indexed_min_heap_update_key regression: pass");
    else
      $display("indexed_min_heap_update_key regression: fail");
    $finish;
  end
endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/imhuk_pkg.sv
rtl/imhuk_ram.sv
rtl/imhuk_dp.sv
rtl/imhuk_ctrl.sv
rtl/indexed_min_heap_update_key.sv
tb/tb_top.sv
